FILE: rtl/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define DIOQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// implication checked at every clock edge outside reset
`define DIOQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dioq_pkg.sv
// shared types and constants of the date-ordered insertion queue
`timescale 1ns / 1ps

package dioq_pkg;

    localparam int unsigned DEF_CAPACITY = 128;
    localparam int unsigned BEAT_W       = 72;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [31:0] tag;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } t_entry;

    // input beat, lowest field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [6:0]  read_index;
        logic [31:0] order_tag;
        logic [4:0]  order_day;
        logic [3:0]  order_month;
        logic [15:0] order_year;
        logic [1:0]  opcode;
    } t_in_beat;

    // output beat, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [7:0]  pending_after;
        logic [31:0] out_tag;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [15:0] out_year;
        logic [1:0]  status;
    } t_out_beat;

    // which logical slot the ram read port looks at
    typedef enum logic [1:0] {
        RD_KM1,
        RD_KM2,
        RD_HEAD,
        RD_IDX
    } t_rd_sel;

    typedef struct packed {
        logic       cap_in;
        logic       k_load;
        logic       k_dec;
        t_rd_sel    rd_sel;
        logic       ram_we;
        logic       wr_item;
        logic       res_ld;
        logic [1:0] res_status;
        logic       res_use_rdata;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       head_inc;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       idx_oob;
        logic       k_zero;
        logic       k_one;
        logic       stored_ge;
        logic       out_free;
    } t_sts;

endpackage

FILE: rtl/dioq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module dioq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dioq_dp.sv
// datapath: entry ram, count and head pointer, scan index, result and output registers
`timescale 1ns / 1ps

module dioq_dp #(
    parameter int unsigned CAPACITY = dioq_pkg::DEF_CAPACITY
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dioq_pkg::t_cmd             i_cmd,
    output dioq_pkg::t_sts             o_sts,
    input  logic [dioq_pkg::BEAT_W-1:0] i_s_tdata,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [dioq_pkg::BEAT_W-1:0] o_m_tdata
);

    import dioq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = (CW > 7) ? CW : 7;
    localparam int unsigned PW = (CW > 8) ? CW : 8;
    localparam int unsigned EW = $bits(t_entry);
    localparam logic [CW:0]   CAP_W  = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

    t_in_beat w_in;

    logic [1:0]    r_op;
    t_entry        r_item;
    logic [6:0]    r_idx;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_k;

    logic [1:0]    r_res_status;
    t_entry        r_res_entry;

    logic          r_out_valid;
    t_out_beat     r_out;

    logic [CW-1:0] w_rli;
    logic [CW:0]   w_rsum;
    logic [CW:0]   w_wsum;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    t_entry        w_rdata;
    t_entry        w_wdata;
    logic [EW-1:0] w_rdata_raw;
    logic [PW-1:0] w_cnt_x;
    logic          w_out_free;

    assign w_in = t_in_beat'(i_s_tdata);

    // logical slot to physical ram address, ring starting at the head
    always_comb begin
        case (i_cmd.rd_sel)
            RD_KM1:  w_rli = r_k - CW'(1);
            RD_KM2:  w_rli = r_k - CW'(2);
            RD_HEAD: w_rli = '0;
            RD_IDX:  w_rli = CW'(r_idx);
            default: w_rli = '0;
        endcase
    end

    assign w_rsum  = (CW + 1)'(r_head) + (CW + 1)'(w_rli);
    assign w_wsum  = (CW + 1)'(r_head) + (CW + 1)'(r_k);
    assign w_raddr = (w_rsum >= CAP_W) ? AW'(w_rsum - CAP_W) : AW'(w_rsum);
    assign w_waddr = (w_wsum >= CAP_W) ? AW'(w_wsum - CAP_W) : AW'(w_wsum);

    assign w_wdata = i_cmd.wr_item ? r_item : w_rdata;

    dioq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = t_entry'(w_rdata_raw);

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_cnt_x    = PW'(r_count);

    always_comb begin
        o_sts.op        = r_op;
        o_sts.full      = (r_count == CAP_C);
        o_sts.empty     = (r_count == '0);
        o_sts.idx_oob   = (IW'(r_idx) >= IW'(r_count));
        o_sts.k_zero    = (r_k == '0);
        o_sts.k_one     = (r_k == CW'(1));
        o_sts.stored_ge = ({w_rdata.year, w_rdata.month, w_rdata.day} >=
                           {r_item.year, r_item.month, r_item.day});
        o_sts.out_free  = w_out_free;
    end

    // captured beat and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op         <= w_in.opcode;
            r_item.year  <= w_in.order_year;
            r_item.month <= w_in.order_month;
            r_item.day   <= w_in.order_day;
            r_item.tag   <= w_in.order_tag;
            r_idx        <= w_in.read_index;
        end
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            r_res_entry  <= i_cmd.res_use_rdata ? w_rdata : '0;
        end
        if (i_cmd.out_ld) begin
            r_out.pad           <= '0;
            r_out.status        <= r_res_status;
            r_out.out_year      <= r_res_entry.year;
            r_out.out_month     <= r_res_entry.month;
            r_out.out_day       <= r_res_entry.day;
            r_out.out_tag       <= r_res_entry.tag;
            r_out.pending_after <= w_cnt_x[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_head      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.head_inc) begin
                r_head <= (r_head == LAST_A) ? '0 : r_head + AW'(1);
            end
            if (i_cmd.k_load) begin
                r_k <= r_count;
            end else if (i_cmd.k_dec) begin
                r_k <= r_k - CW'(1);
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = BEAT_W'(r_out);

endmodule

FILE: rtl/dioq_ctrl.sv
// controller state machine sequencing insert scans, fetches and result hand-off
`timescale 1ns / 1ps

module dioq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  dioq_pkg::t_sts i_sts,
    output dioq_pkg::t_cmd o_cmd
);

    import dioq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INS_ISSUE,
        S_INS_SCAN,
        S_FETCH,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel     = RD_HEAD;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_status = ST_FULL;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.k_load = 1'b1;
                            n_state      = S_INS_ISSUE;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_sts.empty) begin
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.rd_sel = RD_HEAD;
                            n_state      = S_FETCH;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.idx_oob) begin
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.rd_sel = RD_IDX;
                            n_state      = S_FETCH;
                        end
                    end
                    default: begin
                        o_cmd.res_ld = 1'b1;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_INS_ISSUE: begin
                if (i_sts.k_zero) begin
                    o_cmd.ram_we  = 1'b1;
                    o_cmd.wr_item = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.res_ld  = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_sel = RD_KM1;
                    n_state      = S_INS_SCAN;
                end
            end
            S_INS_SCAN: begin
                // read data is slot k-1; move it up while it is not below the new key
                if (i_sts.stored_ge) begin
                    o_cmd.ram_we = 1'b1;
                    o_cmd.k_dec  = 1'b1;
                    o_cmd.rd_sel = RD_KM2;
                    if (i_sts.k_one) begin
                        n_state = S_INS_ISSUE;
                    end
                end else begin
                    o_cmd.ram_we  = 1'b1;
                    o_cmd.wr_item = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.res_ld  = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_FETCH: begin
                o_cmd.res_ld        = 1'b1;
                o_cmd.res_use_rdata = 1'b1;
                if (i_sts.op == OP_REMOVE) begin
                    o_cmd.head_inc = 1'b1;
                    o_cmd.cnt_dec  = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_s_tready = r_ready;

endmodule

FILE: rtl/date_ordered_insertion_queue_top.sv
// date-ordered insertion queue: top level joining controller and datapath
`timescale 1ns / 1ps

// Keeps up to CAPACITY entries sorted by date key (year, month, day).
// Input stream (i_s_*): one beat is one command; insert, remove head or
// read at an index. Output stream (o_m_*): exactly one result beat per
// command, in command order, carrying status, the removed or read entry
// (zero otherwise) and the pending count after the command.
// Steps from the accepted beat until the result beat is presented:
//   insert: from the tail down, entries not below the new key move up one
//           slot, one entry per cycle through the entry ram (at most the
//           pending count), then the new entry is written into the gap
//   remove, read: one fetch from the entry ram; full, empty, range and
//   unused opcode: the status result is loaded with no ram access
// One command is worked on at a time; o_s_tready is high again once the
// result sits in the output register, so the next command can enter while
// that result still waits for the receiver.
// If the receiver stalls, the result beat holds steady and a finished
// following command waits in the controller until the register frees up.
// Reset is synchronous and active low: the queue comes up empty, the output
// register empty and the input ready; the entry ram is not cleared.

module date_ordered_insertion_queue_top #(
    parameter int unsigned CAPACITY = dioq_pkg::DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // opcode, order_year, order_month, order_day, order_tag, read_index, zero pad
    input  logic [dioq_pkg::BEAT_W-1:0] i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // status, out_year, out_month, out_day, out_tag, pending_after, zero pad
    output logic [dioq_pkg::BEAT_W-1:0] o_m_tdata
);

    import dioq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    dioq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dioq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

FILE: rtl/dioq_checker.sv
// port-level checker for the date-ordered insertion queue, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dioq_checker #(
    parameter int unsigned CAPACITY = dioq_pkg::DEF_CAPACITY
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic [dioq_pkg::BEAT_W-1:0] i_s_tdata,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [dioq_pkg::BEAT_W-1:0] o_m_tdata
);

    import dioq_pkg::*;

    localparam logic [7:0] CAP_LO = 8'(CAPACITY % 256);

    t_out_beat w_out;
    logic      w_no_entry;

    assign w_out      = t_out_beat'(o_m_tdata);
    assign w_no_entry = (w_out.out_year == '0) && (w_out.out_month == '0) &&
                        (w_out.out_day == '0) && (w_out.out_tag == '0);

    `DIOQ_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result beat changed while stalled")

    `DIOQ_ASSERT_IMP(a_full_count, o_m_tvalid && (w_out.status == ST_FULL), (w_out.pending_after == CAP_LO) && w_no_entry, "full status without a full queue")

    `DIOQ_ASSERT_IMP(a_empty_count, o_m_tvalid && (w_out.status == ST_EMPTY), (w_out.pending_after == '0) && w_no_entry, "empty status with pending entries")

    `DIOQ_ASSERT_IMP(a_range_zero, o_m_tvalid && (w_out.status == ST_RANGE), w_no_entry, "range status carries entry data")

    `DIOQ_ASSERT_IMP(a_count_bound, o_m_tvalid && (CAPACITY < 256), w_out.pending_after <= CAP_LO, "pending count above capacity")

endmodule

bind date_ordered_insertion_queue_top dioq_checker #(.CAPACITY(CAPACITY)) u_dioq_checker (.*);
